>>> src/multivariate_polynomial_eval_assert.svh
// Assertion macros used by the polynomial evaluator core.
`ifndef MULTIVARIATE_POLYNOMIAL_EVAL_ASSERT_SVH
`define MULTIVARIATE_POLYNOMIAL_EVAL_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MPE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MPE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mpe_pkg.sv
// Package: constants, types and helper functions of the polynomial evaluator.
package mpe_pkg;

  localparam int MAX_TERMS  = 256;
  localparam int MAX_AXES   = 6;
  localparam int MAX_DEGREE = 4;
  localparam int ADDR_W     = $clog2(MAX_TERMS);
  localparam int EXP_W      = 3;
  localparam int CNT_W      = 9;
  localparam int ACC_W      = 56;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_VALUE = 2'd1;
  localparam logic [1:0] FN_DERIV = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  localparam logic REG_NUM_AXES   = 1'b0;
  localparam logic REG_MAX_DEGREE = 1'b1;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef logic [EXP_W-1:0] exp_t;
  typedef exp_t [MAX_AXES-1:0] exp_vec_t;

  typedef struct packed {
    logic [2:0] n;
    logic [2:0] d;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE, S_TERM, S_MUL, S_DER, S_CMUL, S_ACC, S_NEXT, S_FIN
  } state_t;

  localparam logic [CNT_W-1:0] TERM_TBL [MAX_AXES][MAX_DEGREE+1] = '{
    '{9'd1, 9'd2, 9'd3,  9'd4,  9'd5},
    '{9'd1, 9'd3, 9'd6,  9'd10, 9'd15},
    '{9'd1, 9'd4, 9'd10, 9'd20, 9'd35},
    '{9'd1, 9'd5, 9'd15, 9'd35, 9'd70},
    '{9'd1, 9'd6, 9'd21, 9'd56, 9'd126},
    '{9'd1, 9'd7, 9'd28, 9'd84, 9'd210}
  };

  function automatic logic [CNT_W-1:0] term_count(cfg_t c);
    return TERM_TBL[c.n - 3'd1][c.d];
  endfunction

  function automatic logic [EXP_W:0] exp_sum(exp_vec_t e);
    logic [EXP_W:0] s;
    s = '0;
    for (int k = 0; k < MAX_AXES; k++) s = s + (EXP_W+1)'(e[k]);
    return s;
  endfunction

  function automatic exp_vec_t next_exp(exp_vec_t e, cfg_t c);
    exp_vec_t       r;
    logic [EXP_W:0] s;
    logic           found;
    r = e;
    found = 1'b0;
    for (int j = MAX_AXES - 1; j >= 0; j--) begin
      s = '0;
      for (int k = 0; k < MAX_AXES; k++) begin
        if (k <= j) s = s + (EXP_W+1)'(e[k]);
      end
      if (!found && (3'(j) < c.n) && (s < (EXP_W+1)'(c.d))) begin
        r[j] = e[j] + EXP_W'(1);
        for (int k = 0; k < MAX_AXES; k++) begin
          if (k > j) r[k] = '0;
        end
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

>>> src/mpe_if.sv
// Handshake interfaces for the input and result channels.
interface mpe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] x_axis0;
  logic signed [31:0] x_axis1;
  logic signed [31:0] x_axis2;
  logic signed [31:0] x_axis3;
  logic signed [31:0] x_axis4;
  logic signed [31:0] x_axis5;
  logic [2:0]         deriv_axis;

  modport source (output valid, func, coef_index, coef_value, x_axis0, x_axis1, x_axis2,
                  x_axis3, x_axis4, x_axis5, deriv_axis, input ready);
  modport sink (input valid, func, coef_index, coef_value, x_axis0, x_axis1, x_axis2,
                x_axis3, x_axis4, x_axis5, deriv_axis, output ready);
endinterface

interface mpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic [8:0]         term_count;

  modport source (output valid, result_value, status, term_count, input ready);
  modport sink (input valid, result_value, status, term_count, output ready);
endinterface

>>> src/mpe_ram.sv
// Generic single-port RAM with registered read.
module mpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule

>>> src/mpe_cfg.sv
// APB register file: axis count and degree, clamped for the datapath.
module mpe_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mpe_pkg::cfg_t cfg
);
  import mpe_pkg::*;

  logic [2:0] num_axes_r, num_axes_nxt;
  logic [2:0] max_degree_r, max_degree_nxt;
  logic       wr;

  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    num_axes_nxt = num_axes_r;
    max_degree_nxt = max_degree_r;
    if (wr) begin
      case (paddr[2])
        REG_NUM_AXES:   num_axes_nxt = pwdata[2:0];
        REG_MAX_DEGREE: max_degree_nxt = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_axes_r <= 3'd1;
      max_degree_r <= 3'd0;
    end else begin
      num_axes_r <= num_axes_nxt;
      max_degree_r <= max_degree_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_MAX_DEGREE) ? {29'd0, max_degree_r} : {29'd0, num_axes_r};

  always_comb begin
    cfg.n = num_axes_r;
    if (num_axes_r == 3'd0) cfg.n = 3'd1;
    else if (num_axes_r > 3'(MAX_AXES)) cfg.n = 3'(MAX_AXES);
    cfg.d = (max_degree_r > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : max_degree_r;
  end

endmodule

>>> src/mpe_core.sv
// Term sequencer and shared multiply-accumulate datapath.
`include "multivariate_polynomial_eval_assert.svh"
module mpe_core (
  input  logic               clk,
  input  logic               rst_n,
  mpe_in_if.sink             in_if,
  mpe_out_if.source          out_if,
  input  mpe_pkg::cfg_t      cfg,
  output mpe_pkg::ram_req_t  ram_req,
  input  logic [31:0]        ram_rdata
);
  import mpe_pkg::*;

  state_t                state_r, state_nxt;
  logic                  deriv_r, deriv_nxt;
  logic [2:0]            dax_r, dax_nxt;
  logic signed [31:0]    x_r [MAX_AXES];
  exp_vec_t              e_r, e_nxt;
  exp_vec_t              rem_r, rem_nxt;
  logic signed [31:0]    t_r, t_nxt;
  logic signed [47:0]    prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                  flag_r, flag_nxt;
  logic                  err_r, err_nxt;
  logic [ADDR_W-1:0]     p_r, p_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [31:0]    res_r, res_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [CNT_W-1:0]      tcnt_r, tcnt_nxt;

  logic [CNT_W-1:0]      cnt;
  logic                  accept;
  logic [2:0]            sel;
  logic signed [31:0]    mul_a, mul_b;
  logic signed [63:0]    mul_p, rnd;
  logic signed [47:0]    rnd48;
  logic                  rnd_sat;
  logic signed [31:0]    rnd_s32;
  logic signed [35:0]    der_p;
  logic                  der_sat;
  logic signed [31:0]    der_s32;
  logic                  acc_sat;
  logic signed [31:0]    acc_s32;

  assign cnt = term_count(cfg);
  assign in_if.ready = (state_r == S_IDLE);
  assign accept = in_if.valid && in_if.ready;

  always_comb begin
    sel = 3'd0;
    for (int i = MAX_AXES - 1; i >= 0; i--) begin
      if (rem_r[i] != '0) sel = 3'(i);
    end
  end

  always_comb begin
    mul_a = t_r;
    mul_b = x_r[sel];
    if (state_r == S_CMUL) begin
      mul_a = $signed(ram_rdata);
      mul_b = t_r;
    end
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign rnd = mul_p + 64'sd32768;
  assign rnd48 = $signed(rnd[63:16]);
  assign rnd_sat = !((&rnd48[47:31]) || !(|rnd48[47:31]));
  assign rnd_s32 = rnd_sat ? (rnd48[47] ? Q_MIN : Q_MAX) : rnd48[31:0];

  assign der_p = 36'(t_r) * 36'($signed({1'b0, e_r[dax_r]}));
  assign der_sat = !((&der_p[35:31]) || !(|der_p[35:31]));
  assign der_s32 = der_sat ? (der_p[35] ? Q_MIN : Q_MAX) : der_p[31:0];

  assign acc_sat = !((&acc_r[ACC_W-1:31]) || !(|acc_r[ACC_W-1:31]));
  assign acc_s32 = acc_sat ? (acc_r[ACC_W-1] ? Q_MIN : Q_MAX) : acc_r[31:0];

  always_comb begin
    state_nxt = state_r;
    deriv_nxt = deriv_r;
    dax_nxt = dax_r;
    e_nxt = e_r;
    rem_nxt = rem_r;
    t_nxt = t_r;
    prod_nxt = prod_r;
    acc_nxt = acc_r;
    flag_nxt = flag_r;
    err_nxt = err_r;
    p_nxt = p_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    res_nxt = res_r;
    status_nxt = status_r;
    tcnt_nxt = tcnt_r;
    ram_req = '0;
    ram_req.addr = p_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          deriv_nxt = (in_if.func == FN_DERIV);
          dax_nxt = in_if.deriv_axis;
          e_nxt = '0;
          p_nxt = '0;
          acc_nxt = '0;
          flag_nxt = 1'b0;
          err_nxt = 1'b0;
          state_nxt = S_FIN;
          case (in_if.func)
            FN_WRITE: begin
              if (9'(in_if.coef_index) < cnt) begin
                ram_req.we = 1'b1;
                ram_req.addr = in_if.coef_index;
                ram_req.wdata = in_if.coef_value;
              end else begin
                err_nxt = 1'b1;
              end
            end
            FN_VALUE: state_nxt = S_TERM;
            FN_DERIV: begin
              if (in_if.deriv_axis < 3'(MAX_AXES) && in_if.deriv_axis < cfg.n) begin
                state_nxt = S_TERM;
              end
            end
            default: ;
          endcase
        end
      end
      S_TERM: begin
        if (deriv_r && e_r[dax_r] == '0) begin
          state_nxt = S_NEXT;
        end else begin
          t_nxt = Q_ONE;
          rem_nxt = e_r;
          if (deriv_r) rem_nxt[dax_r] = e_r[dax_r] - EXP_W'(1);
          ram_req.re = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (rem_r != '0) begin
          t_nxt = rnd_s32;
          flag_nxt = flag_r || rnd_sat;
          rem_nxt[sel] = rem_r[sel] - EXP_W'(1);
        end else begin
          state_nxt = deriv_r ? S_DER : S_CMUL;
        end
      end
      S_DER: begin
        t_nxt = der_s32;
        flag_nxt = flag_r || der_sat;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        prod_nxt = rnd48;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r);
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (9'(p_r) + 9'd1 < cnt) begin
          p_nxt = p_r + ADDR_W'(1);
          e_nxt = next_exp(e_r, cfg);
          state_nxt = S_TERM;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          res_nxt = acc_s32;
          tcnt_nxt = cnt;
          if (err_r) status_nxt = ST_ERR;
          else if (flag_r || acc_sat) status_nxt = ST_SAT;
          else status_nxt = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deriv_r <= deriv_nxt;
    dax_r <= dax_nxt;
    e_r <= e_nxt;
    rem_r <= rem_nxt;
    t_r <= t_nxt;
    prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    flag_r <= flag_nxt;
    err_r <= err_nxt;
    p_r <= p_nxt;
    res_r <= res_nxt;
    status_r <= status_nxt;
    tcnt_r <= tcnt_nxt;
    if (accept) begin
      x_r[0] <= in_if.x_axis0;
      x_r[1] <= in_if.x_axis1;
      x_r[2] <= in_if.x_axis2;
      x_r[3] <= in_if.x_axis3;
      x_r[4] <= in_if.x_axis4;
      x_r[5] <= in_if.x_axis5;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.result_value = res_r;
  assign out_if.status = status_r;
  assign out_if.term_count = tcnt_r;

  `MPE_ASSERT_IMPL(a_term_in_range, state_r == S_TERM, 9'(p_r) < cnt,
    "term position beyond term count")
  `MPE_ASSERT_IMPL(a_exp_bound, state_r == S_TERM, exp_sum(e_r) <= 4'(cfg.d),
    "exponent vector exceeds degree")
  `MPE_ASSERT_IMPL(a_write_in_range, ram_req.we, 9'(ram_req.addr) < cnt,
    "coefficient write beyond term count")
  `MPE_ASSERT_IMPL(a_out_from_fin, $rose(out_valid_r), $past(state_r == S_FIN),
    "result raised outside finish state")

endmodule

>>> src/multivariate_polynomial_eval.sv
// Top level: total-degree polynomial evaluator with coefficient memory.
//
//   channel   dir   handshake            payload
//   in_if     in    valid/ready          func, coef_index, coef_value, x_axis0..5, deriv_axis
//   out_if    out   valid/ready          result_value, status, term_count
//   cfg       in    APB psel/penable     num_axes at 0x0, max_degree at 0x4
//
// Write, no-op and rejected derivative items go straight from idle to the finish state; an
// evaluation steps through the terms in order, multiplying out each exponent and the coefficient
// on the single shared 32x32 multiplier, one product per cycle.
// One item at a time; a finished result waits in the output register.
// Synchronous active-low reset clears control; the coefficient memory is not cleared.
module multivariate_polynomial_eval (
  input  logic        clk,
  input  logic        rst_n,
  mpe_in_if.sink      in_if,
  mpe_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpe_pkg::*;

  cfg_t        cfg;
  ram_req_t    ram_req;
  logic [31:0] ram_rdata;

  mpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mpe_ram #(
    .WIDTH (32),
    .DEPTH (MAX_TERMS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .re    (ram_req.re),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  mpe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg       (cfg),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

endmodule

>>> sim/multivariate_polynomial_eval_tb.sv
// Testbench for the polynomial evaluator: random items against a built-in predictor.
module multivariate_polynomial_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpe_pkg::*;

  localparam logic [1:0] FN_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int RANDOM_ITEMS = 160;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       coef_index;
    logic [31:0]      coef_value;
    logic [5:0][31:0] x;
    logic [2:0]       deriv_axis;
  } poly_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
    logic [8:0]  count;
  } poly_result_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  mpe_in_if  in_if ();
  mpe_out_if out_if ();

  multivariate_polynomial_eval u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  poly_item_t   pending_q[$];
  poly_result_t result_q[$];
  logic [31:0]  coef_mem [MAX_TERMS];
  logic [2:0]   axes_reg;
  logic [2:0]   degree_reg;
  int n_pushed, n_accepted, n_results, n_mismatch, n_evals, n_sat, n_phases;
  int idle_cycles;
  bit quiet;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap(bit no_gap);
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint clamp32(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic bit advance_exps(ref int e[6], input int n, input int d);
    int s;
    for (int j = n - 1; j >= 0; j--) begin
      s = 0;
      for (int k = 0; k <= j; k++) s += e[k];
      if (s < d) begin
        e[j]++;
        for (int k = j + 1; k < n; k++) e[k] = 0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int terms_for(int n, int d);
    int e[6];
    int c;
    foreach (e[i]) e[i] = 0;
    c = 0;
    do c++; while (c < MAX_TERMS && advance_exps(e, n, d));
    return c;
  endfunction

  function automatic poly_result_t poly_predict(poly_item_t it);
    poly_result_t res;
    int n, d, cnt, dax, ex;
    int e[6];
    longint acc, t;
    bit sat, deriv;
    n = (axes_reg == 0) ? 1 : (axes_reg > MAX_AXES) ? MAX_AXES : axes_reg;
    d = (degree_reg > MAX_DEGREE) ? MAX_DEGREE : degree_reg;
    cnt = terms_for(n, d);
    dax = it.deriv_axis;
    deriv = (it.func == FN_DERIV);
    sat = 1'b0;
    acc = 0;
    res.value = '0;
    res.status = ST_OK;
    res.count = 9'(cnt);
    if (it.func == FN_WRITE) begin
      if (it.coef_index < cnt) coef_mem[it.coef_index] = it.coef_value;
      else res.status = ST_ERR;
    end else if ((it.func == FN_VALUE || deriv) && !(deriv && (dax >= 6 || dax >= n))) begin
      foreach (e[i]) e[i] = 0;
      for (int p = 0; p < cnt; p++) begin
        if (p > 0) void'(advance_exps(e, n, d));
        if (deriv && e[dax] == 0) continue;
        t = 65536;
        for (int i = 0; i < n; i++) begin
          ex = (deriv && i == dax) ? e[i] - 1 : e[i];
          for (int k = 0; k < ex; k++)
            t = clamp32(q_mul(t, longint'($signed(it.x[i]))), sat);
        end
        if (deriv) t = clamp32(t * e[dax], sat);
        acc += q_mul(longint'($signed(coef_mem[p])), t);
      end
      res.value = 32'(clamp32(acc, sat));
      res.status = sat ? ST_SAT : ST_OK;
      n_evals++;
      if (sat) n_sat++;
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_q();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 32'($urandom_range(0, 32'h5FFFF)) - 32'h30000;
    if (r < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic poly_item_t make_item(logic [1:0] func, int idx, int dax);
    poly_item_t it;
    it.func = func;
    it.coef_index = 8'(idx);
    it.coef_value = rand_q();
    foreach (it.x[i]) it.x[i] = rand_q();
    it.deriv_axis = 3'(dax);
    return it;
  endfunction

  task automatic push(poly_item_t it);
    pending_q.push_back(it);
    n_pushed++;
  endtask

  task automatic drain();
    while (n_accepted != n_pushed || result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [2:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_NUM_AXES) axes_reg = val;
    else degree_reg = val;
  endtask

  task automatic set_config(logic [2:0] n, logic [2:0] d);
    drain();
    reg_write(REG_NUM_AXES, n);
    reg_write(REG_MAX_DEGREE, d);
    quiet = ($urandom_range(0, 3) == 0);
    n_phases++;
  endtask

  task automatic random_items(int cnt);
    int n, tc, r;
    n = (axes_reg == 0) ? 1 : (axes_reg > MAX_AXES) ? MAX_AXES : axes_reg;
    tc = terms_for(n, (degree_reg > MAX_DEGREE) ? MAX_DEGREE : degree_reg);
    repeat (cnt) begin
      r = $urandom_range(0, 99);
      if (r < 35) push(make_item(FN_VALUE, $urandom, 0));
      else if (r < 70)
        push(make_item(FN_DERIV, $urandom, ($urandom_range(0, 4) == 0) ?
                       $urandom_range(0, 7) : $urandom_range(0, n - 1)));
      else if (r < 90) push(make_item(FN_WRITE, $urandom_range(0, tc - 1), 0));
      else if (r < 95) push(make_item(FN_WRITE, $urandom, $urandom));
      else push(make_item(FN_NOP, $urandom, $urandom));
    end
  endtask

  // input driver
  always @(posedge clk) begin
    static int gap = 0;
    static poly_item_t cur;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        result_q.push_back(poly_predict(cur));
        n_accepted++;
      end
      if (gap > 0) begin
        gap--;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.func <= cur.func;
        in_if.coef_index <= cur.coef_index;
        in_if.coef_value <= cur.coef_value;
        in_if.x_axis0 <= cur.x[0];
        in_if.x_axis1 <= cur.x[1];
        in_if.x_axis2 <= cur.x[2];
        in_if.x_axis3 <= cur.x[3];
        in_if.x_axis4 <= cur.x[4];
        in_if.x_axis5 <= cur.x[5];
        in_if.deriv_axis <= cur.deriv_axis;
        gap = pick_gap(quiet);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    static int stall = 0;
    poly_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result value=%h status=%0d count=%0d",
                                        out_if.result_value, out_if.status, out_if.term_count);
      end else begin
        exp_r = result_q.pop_front();
        if (out_if.result_value !== exp_r.value || out_if.status !== exp_r.status ||
            out_if.term_count !== exp_r.count) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: value exp %h got %h, status exp %0d got %0d, count exp %0d got %0d",
                     exp_r.value, out_if.result_value, exp_r.status, out_if.status,
                     exp_r.count, out_if.term_count);
        end
      end
    end
    if (stall > 0) begin
      stall--;
      out_if.ready <= 1'b0;
    end else begin
      stall = pick_gap(quiet);
      out_if.ready <= (stall == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int done;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    axes_reg = 3'd1;
    degree_reg = 3'd0;
    idle_cycles = 0;
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: one term
    push(make_item(FN_WRITE, 0, 0));
    push(make_item(FN_WRITE, 5, 0));
    push(make_item(FN_WRITE, 255, 0));
    push(make_item(FN_VALUE, 0, 0));
    push(make_item(FN_DERIV, 0, 0));
    push(make_item(FN_DERIV, 0, 7));
    push(make_item(FN_NOP, 0, 0));

    // largest term set: fill every reachable coefficient
    set_config(3'd6, 3'd4);
    for (int i = 0; i < 210; i++) push(make_item(FN_WRITE, i, 0));
    push(make_item(FN_WRITE, 210, 0));
    begin
      poly_item_t it;
      it = make_item(FN_VALUE, 0, 0);
      it.x = {6{32'h7FFF_FFFF}};
      push(it);
      it.x = {6{32'h8000_0000}};
      push(it);
      it.func = FN_DERIV;
      for (int a = 0; a < 8; a++) begin
        it.deriv_axis = 3'(a);
        push(it);
      end
    end

    set_config(3'd7, 3'd7);
    random_items(6);
    set_config(3'd0, 3'd0);
    random_items(6);
    set_config(3'd1, 3'd4);
    random_items(6);

    done = 0;
    while (done < RANDOM_ITEMS) begin
      int k;
      if ($urandom_range(0, 3) == 0) set_config($urandom_range(0, 7), $urandom_range(0, 7));
      else set_config($urandom_range(1, 3), $urandom_range(0, 3));
      k = $urandom_range(10, 30);
      random_items(k);
      done += k;
    end
    drain();

    $display("covered %0d items in %0d register settings, %0d evaluations (%0d saturated)",
             n_accepted, n_phases, n_evals, n_sat);
    $display("%0d results checked, %0d mismatches", n_results, n_mismatch);
    if (n_mismatch == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
